>>> design/sss_pkg.sv
`timescale 1ns / 1ps
package sss_pkg;

    // field widths of the stream words
    localparam int DT_W     = 15;
    localparam int DATA_W   = 16;
    localparam int IDX_W    = 4;
    localparam int STATE_W  = 32;
    localparam int SUM_W    = 48;
    localparam int OUT_W    = 32;

    // internal widths of the decay path
    localparam int M_W      = 30;
    localparam int U_W      = 31;
    localparam int TAB_W    = 17;
    localparam int DECAY_W  = 25;

    localparam int DEF_STATE_DEPTH = 16;
    localparam int INDEX_COUNT     = 1 << IDX_W;

    // log2(e) in Q.16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_M7,
        S_OUT
    } t_state;

    // 2^(-i/16) in Q.16 for i = 0..16
    function automatic logic [TAB_W-1:0] pow2_neg(input logic [4:0] i);
        logic [TAB_W-1:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

>>> design/sss_if.sv
`timescale 1ns / 1ps
interface sss_in_if
    import sss_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [DT_W-1:0]          step_size;
    logic signed [DATA_W-1:0] sample_value;
    logic signed [DATA_W-1:0] decay_coef;
    logic signed [DATA_W-1:0] input_coef;
    logic signed [DATA_W-1:0] output_coef;
    logic signed [DATA_W-1:0] skip_gain;
    logic [IDX_W-1:0]         state_index;
    logic                     first_step;
    logic                     last_state;

    modport source (
        output valid, step_size, sample_value, decay_coef, input_coef,
               output_coef, skip_gain, state_index, first_step, last_state,
        input  ready
    );
    modport sink (
        input  valid, step_size, sample_value, decay_coef, input_coef,
               output_coef, skip_gain, state_index, first_step, last_state,
        output ready
    );
endinterface

interface sss_out_if
    import sss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] channel_output;
    logic                    saturated;

    modport source (output valid, channel_output, saturated, input ready);
    modport sink (input valid, channel_output, saturated, output ready);
endinterface

>>> design/sss_decay.sv
`timescale 1ns / 1ps
module sss_decay
    import sss_pkg::*;
(
    input  logic               i_clk,
    input  logic [M_W-1:0]     i_m,
    output logic [DECAY_W-1:0] o_decay
);

    logic [U_W-1:0]     r_u;
    logic [6:0]         r_k;
    logic [TAB_W-1:0]   r_ta;
    logic [31:0]        r_interp;
    logic [DECAY_W-1:0] r_decay;

    logic [M_W+16:0]    w_mprod;
    logic [3:0]         w_i;
    logic [TAB_W-1:0]   w_ta;
    logic [TAB_W-1:0]   w_tb;
    logic [11:0]        w_diff;
    logic [TAB_W-1:0]   w_v;
    logic [DECAY_W-1:0] w_shift;

    // convert the exponent to base 2, split into integer and fraction
    assign w_mprod = i_m * LOG2E_Q16;
    assign w_i     = r_u[23:20];
    assign w_ta    = pow2_neg({1'b0, w_i});
    assign w_tb    = pow2_neg({1'b0, w_i} + 5'd1);
    assign w_diff  = 12'(w_ta - w_tb);

    // interpolate and apply the integer shift
    assign w_v     = r_ta - TAB_W'(r_interp[31:20]);
    assign w_shift = {w_v, 8'd0} >> r_k;

    always_ff @(posedge i_clk) begin
        r_u      <= U_W'(w_mprod >> 16);
        r_k      <= r_u[30:24];
        r_ta     <= w_ta;
        r_interp <= w_diff * r_u[19:0];
        r_decay  <= (r_k >= 7'd25) ? '0 : w_shift;
    end

    assign o_decay = r_decay;

endmodule

>>> design/selective_state_space_scan.sv
`timescale 1ns / 1ps
// Selective state-space scan, one channel at a time, one state element per word.
// i_in carries a word per state element of a time step: dt, x, A, B, C, D, the
// state index and the first-step and last-state flags. o_out carries one word
// per time step (the word whose last_state is set): y in Q8.24 and a flag that
// is set when y, the running sum or a state update was clipped during the step.
// The input takes one word at a time and stays closed while the sequencer is busy
// with it; a last-state word also holds it while y is loaded. The sequencer walks
// one word through the state memory read, the three-stage exponential unit, the
// state multiply and write-back, and the output multiply-accumulate; o_out.valid
// rises once the last-state word has reached the output register.
// The output register lets the next words start while y waits; if the receiver
// stalls, the following last-state word waits in its final cycle until the
// pending y is taken.
// Reset (i_rst_n low, synchronous) marks all state entries empty, so they read
// as zero, and clears the running sum, the clip flag and the output valid flag.
module selective_state_space_scan
    import sss_pkg::*;
#(
    parameter int STATE_DEPTH = DEF_STATE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sss_in_if.sink    i_in,
    sss_out_if.source o_out
);

    localparam int IW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

    t_state r_state;
    t_state n_state;

    logic                       r_first;
    logic                       r_last;
    logic [IW-1:0]              r_idx;
    logic signed [DATA_W-1:0]   r_x;
    logic signed [DATA_W-1:0]   r_cc;
    logic signed [DATA_W-1:0]   r_dg;
    logic [M_W-1:0]             r_m;
    logic signed [31:0]         r_dtb;
    logic signed [47:0]         r_dtbx;
    logic signed [31:0]         r_dx;
    logic signed [STATE_W-1:0]  r_hold;
    logic signed [57:0]         r_prod;
    logic signed [STATE_W-1:0]  r_hnew;
    logic signed [47:0]         r_cprod;
    logic signed [SUM_W-1:0]    r_sum;
    logic                       r_clip;
    logic [STATE_DEPTH-1:0]     r_valid;
    logic signed [STATE_W-1:0]  r_mem_q;
    logic                       r_hit;
    logic                       r_ov;
    logic signed [OUT_W-1:0]    r_oy;
    logic                       r_osat;

    logic signed [STATE_W-1:0]  mem [STATE_DEPTH];

    logic [IW-1:0]              w_idx_map [INDEX_COUNT];
    logic [IW-1:0]              w_addr;
    logic                       w_accept;
    logic                       w_load;
    logic signed [16:0]         w_dt;
    logic signed [32:0]         w_z;
    logic signed [32:0]         w_negz;
    logic [DECAY_W-1:0]         w_decay;
    logic signed [36:0]         w_hsum;
    logic                       w_hclip;
    logic signed [STATE_W-1:0]  w_hsat;
    logic signed [48:0]         w_ssum;
    logic                       w_sclip;
    logic signed [SUM_W-1:0]    w_ssat;
    logic signed [49:0]         w_ysum;
    logic                       w_yclip;
    logic signed [OUT_W-1:0]    w_ysat;

    // fold the state index into the store
    for (genvar g = 0; g < INDEX_COUNT; g++) begin : g_idx
        assign w_idx_map[g] = IW'(g % STATE_DEPTH);
    end
    assign w_addr = w_idx_map[i_in.state_index];

    // exponent argument: -(dt * A), zero when dt * A is not negative
    assign w_dt   = $signed({2'b00, i_in.step_size});
    assign w_z    = 33'(w_dt * i_in.decay_coef);
    assign w_negz = -w_z;

    sss_decay u_decay (
        .i_clk   (i_clk),
        .i_m     (r_m),
        .o_decay (w_decay)
    );

    // state update with saturation to 32 bits
    assign w_hsum  = 37'(r_prod >>> 24) + 37'(r_dtbx >>> 12);
    assign w_hclip = (!w_hsum[36] && (|w_hsum[35:31])) || (w_hsum[36] && !(&w_hsum[35:31]));
    assign w_hsat  = !w_hclip ? w_hsum[31:0] : (w_hsum[36] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    // running sum with saturation to 48 bits
    assign w_ssum  = 49'(r_sum) + 49'(r_cprod >>> 12);
    assign w_sclip = w_ssum[48] != w_ssum[47];
    assign w_ssat  = !w_sclip ? w_ssum[47:0]
                   : (w_ssum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

    // output with feedthrough, saturated to 32 bits
    assign w_ysum  = 50'(r_sum) + 50'(r_dx);
    assign w_yclip = (!w_ysum[49] && (|w_ysum[48:31])) || (w_ysum[49] && !(&w_ysum[48:31]));
    assign w_ysat  = !w_yclip ? w_ysum[31:0] : (w_ysum[49] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    // advance the sequencer
    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = i_rst_n;
                if (i_in.valid) begin
                    n_state = S_M1;
                end
            end
            S_M1: n_state = S_M2;
            S_M2: n_state = S_M3;
            S_M3: n_state = S_M4;
            S_M4: n_state = S_M5;
            S_M5: n_state = S_M6;
            S_M6: n_state = S_M7;
            S_M7: n_state = r_last ? S_OUT : S_IDLE;
            S_OUT: begin
                if (!r_ov || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
    assign w_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // read the state memory at accept, write back the new value
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem_q <= mem[w_addr];
        end
        if (r_state == S_M5) begin
            mem[r_idx] <= w_hsat;
        end
    end

    // entry valid bits, running sum and clip flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_sum   <= '0;
            r_clip  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_hit <= r_valid[w_addr];
            end
            if (r_state == S_M5) begin
                r_valid[r_idx] <= 1'b1;
                if (w_hclip) begin
                    r_clip <= 1'b1;
                end
            end
            if (r_state == S_M7) begin
                r_sum <= w_ssat;
                if (w_sclip) begin
                    r_clip <= 1'b1;
                end
            end
            if (w_load) begin
                r_sum  <= '0;
                r_clip <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= i_in.first_step;
            r_last  <= i_in.last_state;
            r_idx   <= w_addr;
            r_x     <= i_in.sample_value;
            r_cc    <= i_in.output_coef;
            r_dg    <= i_in.skip_gain;
            r_m     <= w_z[32] ? w_negz[M_W-1:0] : '0;
            r_dtb   <= 32'(w_dt * i_in.input_coef);
        end
        if (r_state == S_M1) begin
            r_dtbx <= 48'(r_dtb * r_x);
            r_dx   <= 32'(r_dg * r_x);
            r_hold <= (r_first || !r_hit) ? '0 : r_mem_q;
        end
        if (r_state == S_M4) begin
            r_prod <= 58'($signed({1'b0, w_decay}) * r_hold);
        end
        if (r_state == S_M5) begin
            r_hnew <= w_hsat;
        end
        if (r_state == S_M6) begin
            r_cprod <= 48'(r_cc * r_hnew);
        end
        if (w_load) begin
            r_oy   <= w_ysat;
            r_osat <= r_clip || w_yclip;
        end
    end

    // hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.channel_output = r_oy;
    assign o_out.saturated      = r_osat;

endmodule

>>> design/sss_checker.sv
`timescale 1ns / 1ps
module sss_checker
    import sss_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [OUT_W-1:0]  i_out_data,
    input logic              i_out_sat
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data) && $stable(i_out_sat))
        else $error("output word changed while stalled");

    // one word at a time: the input closes after each accept
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted on back-to-back cycles");

    // a new output word is loaded only while the input is closed
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("output word appeared while input was open");

endmodule

bind selective_state_space_scan sss_checker u_sss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.channel_output),
    .i_out_sat   (o_out.saturated)
);
